>>> hdl/ppu_pkg.sv
package ppu_pkg;

  // Memory sizes and address widths.
  localparam int unsigned VRAM_BYTES    = 2048;
  localparam int unsigned OAM_BYTES     = 256;
  localparam int unsigned PATTERN_BYTES = 8192;
  localparam int unsigned VRAM_AW       = $clog2(VRAM_BYTES);
  localparam int unsigned OAM_AW        = $clog2(OAM_BYTES);
  localparam int unsigned PAT_AW        = $clog2(PATTERN_BYTES);

  // Address decoding constants.
  localparam logic [15:0] NT_FIRST   = 16'h2000;
  localparam logic [15:0] NT_LAST    = 16'h2FFF;
  localparam logic [15:0] HI_KEEP    = 16'hFF00;
  localparam logic [10:0] NT_MASK    = 11'h7FF;
  localparam logic [7:0]  ADDR_HI_M  = 8'h3F;
  localparam logic [7:0]  STATUS_CLR = 8'h7F;
  localparam logic [15:0] STEP_ONE   = 16'd1;
  localparam logic [15:0] STEP_ROW   = 16'd32;
  localparam int unsigned CTRL_INC_BIT = 2;

  // Register access codes.
  typedef enum logic [3:0] {
    OP_RDSTATUS  = 4'd0,
    OP_RDOAM     = 4'd1,
    OP_RDDATA    = 4'd2,
    OP_WRCTRL    = 4'd3,
    OP_WRMASK    = 4'd4,
    OP_WROAMADDR = 4'd5,
    OP_WROAM     = 4'd6,
    OP_WRSCROLL  = 4'd7,
    OP_WRADDR    = 4'd8,
    OP_WRDATA    = 4'd9,
    OP_LOADCHR   = 4'd10,
    OP_SETSTATUS = 4'd11
  } op_e;

  // Requests from the control logic to the memories.
  typedef struct packed {
    logic               rd_en;
    logic [VRAM_AW-1:0] nt_raddr;
    logic [OAM_AW-1:0]  oam_raddr;
    logic [PAT_AW-1:0]  pat_raddr;
    logic               nt_we;
    logic [VRAM_AW-1:0] nt_waddr;
    logic [7:0]         nt_wdata;
    logic               oam_we;
    logic [OAM_AW-1:0]  oam_waddr;
    logic [7:0]         oam_wdata;
    logic               pat_we;
    logic [PAT_AW-1:0]  pat_waddr;
    logic [7:0]         pat_wdata;
  } mem_req_t;

  // Registered read data from the memories.
  typedef struct packed {
    logic [7:0] nt_rdata;
    logic [7:0] oam_rdata;
    logic [7:0] pat_rdata;
  } mem_rsp_t;

endpackage

>>> hdl/ppu_mem.sv
module ppu_mem (
  input  logic              clk_i,
  input  ppu_pkg::mem_req_t req_i,
  output ppu_pkg::mem_rsp_t rsp_o
);
  import ppu_pkg::*;

  logic [7:0] nt_mem  [VRAM_BYTES];
  logic [7:0] oam_mem [OAM_BYTES];
  logic [7:0] pat_mem [PATTERN_BYTES];

  logic [7:0] nt_rdata_q;
  logic [7:0] oam_rdata_q;
  logic [7:0] pat_rdata_q;

  // Name table RAM: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.nt_we) begin
      nt_mem[req_i.nt_waddr] <= req_i.nt_wdata;
    end
    if (req_i.rd_en) begin
      nt_rdata_q <= nt_mem[req_i.nt_raddr];
    end
  end

  // Sprite attribute RAM.
  always_ff @(posedge clk_i) begin
    if (req_i.oam_we) begin
      oam_mem[req_i.oam_waddr] <= req_i.oam_wdata;
    end
    if (req_i.rd_en) begin
      oam_rdata_q <= oam_mem[req_i.oam_raddr];
    end
  end

  // Pattern memory, loaded by the host before it is read.
  always_ff @(posedge clk_i) begin
    if (req_i.pat_we) begin
      pat_mem[req_i.pat_waddr] <= req_i.pat_wdata;
    end
    if (req_i.rd_en) begin
      pat_rdata_q <= pat_mem[req_i.pat_raddr];
    end
  end

  assign rsp_o.nt_rdata  = nt_rdata_q;
  assign rsp_o.oam_rdata = oam_rdata_q;
  assign rsp_o.pat_rdata = pat_rdata_q;

endmodule

>>> hdl/ppu_register_port.sv
// Channel     | Signals                                          | Direction
// ------------+--------------------------------------------------+----------
// access      | start, busy (out), operation_i, value_i,         | in
//             | pattern_address_i                                |
// result      | done_o, read_value_o                             | out
// cartridge   | cfg_valid_i, cfg_ready_o (out), cfg_data_i       | in
//
// For each access the memories are read at the accepting edge, and the execute
// state that follows modifies state and writes back; the result strobe is registered
// from the execute state, while the next access may already be accepted.
// After reset a clearing pass zeroes every name table and sprite RAM entry,
// with busy held high. The receiver cannot stall the result.
// The cartridge register is written only while idle with no item starting.
module ppu_register_port (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  operation_i,
  input  logic [7:0]  value_i,
  input  logic [12:0] pattern_address_i,
  output logic        done_o,
  output logic [7:0]  read_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);
  import ppu_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [VRAM_AW-1:0] clr_q, clr_d;

  logic [3:0]        op_q;
  logic [7:0]        val_q;
  logic [PAT_AW-1:0] paddr_q;

  logic [15:0] vaddr_q, vaddr_d;
  logic        toggle_q, toggle_d;
  logic [7:0]  rbuf_q, rbuf_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [7:0]  mask_q, mask_d;
  logic [7:0]  status_q, status_d;
  logic [7:0]  sptr_q, sptr_d;
  logic [7:0]  scroll_h_q, scroll_h_d;
  logic [7:0]  scroll_v_q, scroll_v_d;
  logic        cart_q;
  logic        done_q;
  logic [7:0]  rval_q, rval_d;

  logic               accept;
  logic [15:0]        step_amt;
  logic [15:0]        vaddr_step;
  logic               in_nt_range;
  logic [VRAM_AW-1:0] nt_idx;
  mem_req_t           mem_req;
  mem_rsp_t           mem_rsp;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = !busy && !start;
  assign done_o      = done_q;
  assign read_value_o = rval_q;

  // Address stepping and name table decoding.
  assign step_amt    = ctrl_q[CTRL_INC_BIT] ? STEP_ROW : STEP_ONE;
  assign vaddr_step  = vaddr_q + step_amt;
  assign in_nt_range = (vaddr_q >= NT_FIRST) && (vaddr_q <= NT_LAST);
  assign nt_idx      = VRAM_AW'(vaddr_q[10:0] & NT_MASK);

  ppu_mem u_mem (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

  // Sequencer: clearing pass, idle, then an execute state for each item.
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == {VRAM_AW{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Memory requests: reads at accept, zero writes during the clearing pass, writes in the execute cycle.
  always_comb begin
    mem_req           = '0;
    mem_req.rd_en     = accept;
    mem_req.nt_raddr  = nt_idx;
    mem_req.oam_raddr = sptr_q[OAM_AW-1:0];
    mem_req.pat_raddr = vaddr_q[PAT_AW-1:0];
    mem_req.nt_waddr  = nt_idx;
    mem_req.nt_wdata  = val_q;
    mem_req.oam_waddr = sptr_q[OAM_AW-1:0];
    mem_req.oam_wdata = val_q;
    mem_req.pat_waddr = paddr_q;
    mem_req.pat_wdata = val_q;
    if (state_q == ST_CLEAR) begin
      mem_req.nt_we     = 1'b1;
      mem_req.nt_waddr  = clr_q;
      mem_req.nt_wdata  = '0;
      mem_req.oam_we    = 1'b1;
      mem_req.oam_waddr = clr_q[OAM_AW-1:0];
      mem_req.oam_wdata = '0;
    end else if (state_q == ST_EXEC) begin
      mem_req.nt_we  = (op_q == OP_WRDATA) && in_nt_range;
      mem_req.oam_we = (op_q == OP_WROAM);
      mem_req.pat_we = (op_q == OP_LOADCHR);
    end
  end

  // Register updates and result for the item in execution.
  always_comb begin
    vaddr_d    = vaddr_q;
    toggle_d   = toggle_q;
    rbuf_d     = rbuf_q;
    ctrl_d     = ctrl_q;
    mask_d     = mask_q;
    status_d   = status_q;
    sptr_d     = sptr_q;
    scroll_h_d = scroll_h_q;
    scroll_v_d = scroll_v_q;
    rval_d     = '0;
    if (state_q == ST_EXEC) begin
      unique case (op_q)
        OP_RDSTATUS: begin
          rval_d   = status_q;
          status_d = status_q & STATUS_CLR;
          toggle_d = 1'b0;
        end
        OP_RDOAM: begin
          rval_d = mem_rsp.oam_rdata;
        end
        OP_RDDATA: begin
          rval_d  = rbuf_q;
          rbuf_d  = ((vaddr_q < NT_FIRST) && cart_q) ? mem_rsp.pat_rdata
                                                     : mem_rsp.nt_rdata;
          vaddr_d = vaddr_step;
        end
        OP_WRCTRL: begin
          ctrl_d = val_q;
        end
        OP_WRMASK: begin
          mask_d = val_q;
        end
        OP_WROAMADDR: begin
          sptr_d = val_q;
        end
        OP_WROAM: begin
          sptr_d = sptr_q + 8'd1;
        end
        OP_WRSCROLL: begin
          if (!toggle_q) begin
            scroll_h_d = val_q;
          end else begin
            scroll_v_d = val_q;
          end
          toggle_d = !toggle_q;
        end
        OP_WRADDR: begin
          if (!toggle_q) begin
            vaddr_d = {val_q & ADDR_HI_M, 8'h00};
          end else begin
            vaddr_d = (vaddr_q & HI_KEEP) | {8'h00, val_q};
          end
          toggle_d = !toggle_q;
        end
        OP_WRDATA: begin
          vaddr_d = vaddr_step;
        end
        OP_SETSTATUS: begin
          status_d = status_q | val_q;
        end
        default: begin
          rval_d = '0;
        end
      endcase
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      done_q     <= 1'b0;
      vaddr_q    <= '0;
      toggle_q   <= 1'b0;
      rbuf_q     <= '0;
      ctrl_q     <= '0;
      mask_q     <= '0;
      status_q   <= '0;
      sptr_q     <= '0;
      scroll_h_q <= '0;
      scroll_v_q <= '0;
      cart_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      done_q     <= (state_q == ST_EXEC);
      vaddr_q    <= vaddr_d;
      toggle_q   <= toggle_d;
      rbuf_q     <= rbuf_d;
      ctrl_q     <= ctrl_d;
      mask_q     <= mask_d;
      status_q   <= status_d;
      sptr_q     <= sptr_d;
      scroll_h_q <= scroll_h_d;
      scroll_v_q <= scroll_v_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cart_q <= cfg_data_i;
      end
    end
  end

  // Captured item fields and the result byte.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= operation_i;
      val_q   <= value_i;
      paddr_q <= pattern_address_i;
    end
    rval_q <= rval_d;
  end

  a_done_in_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == ST_IDLE))
    else $error("result strobe outside idle");

  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("accepted item did not enter execution");

  a_exec_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> done_o)
    else $error("execution did not produce a result");

  a_nonread_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && op_q != OP_RDSTATUS && op_q != OP_RDOAM && op_q != OP_RDDATA)
      |-> (read_value_o == 8'h00))
    else $error("non-read item returned a nonzero byte");

endmodule

>>> test/ppu_register_port_tb.sv
`timescale 1ns / 1ps

module ppu_register_port_tb;
  import ppu_pkg::*;

  // Code outside the defined access set; the block must ignore it.
  localparam logic [3:0] OP_UNUSED_LAST = 4'd15;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned IDLE_LIMIT = 10000;
  localparam int unsigned PHASES = 5;
  localparam int unsigned ITEMS_PER_PHASE = 250;

  // Shadow copy of the register port: predicts the read value of every
  // accepted access and checks the results against those predictions.
  class ppu_shadow;
    logic [7:0]  name_table [VRAM_BYTES];
    logic [7:0]  sprite_ram [OAM_BYTES];
    logic [7:0]  pattern [PATTERN_BYTES];
    bit          pattern_loaded [PATTERN_BYTES];
    logic [15:0] vaddr;
    bit          toggle;
    logic [7:0]  rbuf;
    logic [7:0]  ctrl;
    logic [7:0]  mask;
    logic [7:0]  status;
    logic [7:0]  sprite_ptr;
    logic [7:0]  scroll_x;
    logic [7:0]  scroll_y;
    bit          cartridge;
    logic [7:0]  read_values_due [$];
    int unsigned errors;

    function new();
      foreach (name_table[i]) name_table[i] = '0;
      foreach (sprite_ram[i]) sprite_ram[i] = '0;
      foreach (pattern[i]) begin
        pattern[i] = '0;
        pattern_loaded[i] = 1'b0;
      end
      vaddr = '0;
      toggle = 1'b0;
      rbuf = '0;
      ctrl = '0;
      mask = '0;
      status = '0;
      sprite_ptr = '0;
      scroll_x = '0;
      scroll_y = '0;
      cartridge = 1'b0;
      errors = 0;
    endfunction

    function int nt_index(logic [15:0] a);
      return int'(a & {5'b0, NT_MASK}) % VRAM_BYTES;
    endfunction

    function void advance_address();
      vaddr = vaddr + (ctrl[CTRL_INC_BIT] ? STEP_ROW : STEP_ONE);
    endfunction

    // True when a data read now would fetch a pattern byte never loaded.
    function bit reads_unloaded_pattern(logic [3:0] op);
      return op == OP_RDDATA && cartridge && vaddr < NT_FIRST &&
             !pattern_loaded[vaddr[PAT_AW-1:0]];
    endfunction

    // Applies one accepted access and queues the read value it returns.
    function void record_access(logic [3:0] op, logic [7:0] val, logic [12:0] pa);
      logic [7:0]  rv;
      logic [15:0] a;
      rv = '0;
      a = vaddr;
      case (op)
        OP_RDSTATUS: begin
          rv = status;
          status = status & STATUS_CLR;
          toggle = 1'b0;
        end
        OP_RDOAM: rv = sprite_ram[sprite_ptr];
        OP_RDDATA: begin
          rv = rbuf;
          if (a < NT_FIRST && cartridge) rbuf = pattern[a[PAT_AW-1:0]];
          else rbuf = name_table[nt_index(a)];
          advance_address();
        end
        OP_WRCTRL: ctrl = val;
        OP_WRMASK: mask = val;
        OP_WROAMADDR: sprite_ptr = val;
        OP_WROAM: begin
          sprite_ram[sprite_ptr] = val;
          sprite_ptr = sprite_ptr + 8'd1;
        end
        OP_WRSCROLL: begin
          if (!toggle) scroll_x = val;
          else scroll_y = val;
          toggle = !toggle;
        end
        OP_WRADDR: begin
          if (!toggle) vaddr = {val & ADDR_HI_M, 8'h00};
          else vaddr = (vaddr & HI_KEEP) | {8'h00, val};
          toggle = !toggle;
        end
        OP_WRDATA: begin
          if (a >= NT_FIRST && a <= NT_LAST) name_table[nt_index(a)] = val;
          advance_address();
        end
        OP_LOADCHR: begin
          pattern[pa] = val;
          pattern_loaded[pa] = 1'b1;
        end
        OP_SETSTATUS: status = status | val;
        default: ;
      endcase
      read_values_due.push_back(rv);
    endfunction

    function void check_read_value(logic [7:0] got);
      logic [7:0] want;
      if (read_values_due.size() == 0) begin
        $error("read_value: expected none, actual %02h", got);
        errors++;
      end else begin
        want = read_values_due.pop_front();
        if (got !== want) begin
          $error("read_value: expected %02h, actual %02h", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  operation_i = '0;
  logic [7:0]  value_i = '0;
  logic [12:0] pattern_address_i = '0;
  logic        done_o;
  logic [7:0]  read_value_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;

  ppu_shadow   tracker = new();
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;

  ppu_register_port dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .operation_i       (operation_i),
    .value_i           (value_i),
    .pattern_address_i (pattern_address_i),
    .done_o            (done_o),
    .read_value_o      (read_value_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Every result strobe is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.check_read_value(read_value_o);
  end

  // Hang detection: any handshake or result restarts the count.
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) idle = 0;
      else idle++;
    end
    $display("ppu_register_port_tb: FAIL");
    $finish;
  end

  // Issues one access in bursts with random gaps between them.
  task automatic send(logic [3:0] op, logic [7:0] val, logic [12:0] pa);
    int unsigned gap;
    // Never fetch pattern memory that holds no data yet; load it instead.
    if (tracker.reads_unloaded_pattern(op)) begin
      op = OP_LOADCHR;
      pa = tracker.vaddr[PAT_AW-1:0];
    end
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    start <= 1'b1;
    operation_i <= op;
    value_i <= val;
    pattern_address_i <= pa;
    do @(posedge clk_i); while (busy);
    tracker.record_access(op, val, pa);
    items_sent++;
  endtask

  // Holds the sender off until every predicted result has come back.
  task automatic wait_for_results();
    start <= 1'b0;
    burst_left = 0;
    while (tracker.read_values_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cartridge(logic present);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= present;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.cartridge = present;
  endtask

  // One random access sequence; most are well formed, some are noise.
  task automatic random_sequence();
    int unsigned pick;
    int unsigned n;
    logic [5:0]  region;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // Reset the latch, set a full address, then run data accesses.
      send(OP_RDSTATUS, 8'($urandom), 13'($urandom));
      n = $urandom_range(0, 9);
      if (n < 5) region = 6'($urandom_range(6'h20, 6'h2F));
      else if (n < 8) region = 6'($urandom_range(6'h00, 6'h1F));
      else region = 6'($urandom_range(6'h30, 6'h3F));
      send(OP_WRADDR, {2'($urandom), region}, 13'($urandom));
      send(OP_WRADDR, 8'($urandom), 13'($urandom));
      n = $urandom_range(1, 6);
      repeat (n) begin
        send($urandom_range(0, 1) ? OP_RDDATA : OP_WRDATA, 8'($urandom), 13'($urandom));
      end
    end else if (pick < 55) begin
      send(OP_WROAMADDR, 8'($urandom), 13'($urandom));
      n = $urandom_range(1, 4);
      repeat (n) begin
        send($urandom_range(0, 1) ? OP_WROAM : OP_RDOAM, 8'($urandom), 13'($urandom));
      end
    end else if (pick < 65) begin
      send(OP_RDSTATUS, 8'($urandom), 13'($urandom));
      send(OP_WRSCROLL, 8'($urandom), 13'($urandom));
      send(OP_WRSCROLL, 8'($urandom), 13'($urandom));
    end else if (pick < 75) begin
      send(OP_LOADCHR, 8'($urandom), 13'($urandom));
    end else if (pick < 85) begin
      case ($urandom_range(0, 2))
        0: send(OP_WRCTRL, 8'($urandom), 13'($urandom));
        1: send(OP_WRMASK, 8'($urandom), 13'($urandom));
        default: send(OP_SETSTATUS, 8'($urandom), 13'($urandom));
      endcase
    end else begin
      // Any code, unused ones and half-finished latch sequences included.
      send(4'($urandom_range(0, 15)), 8'($urandom), 13'($urandom));
    end
    if ($urandom_range(0, 49) == 0) wait_for_results();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_cartridge(1'b0);

    // Directed accesses: status bits, sprite pointer wrap, both latch
    // phases, writes outside the name table, and the row-sized step.
    send(OP_RDSTATUS, 8'h00, 13'h0000);
    send(OP_SETSTATUS, 8'hFF, 13'h1FFF);
    send(OP_RDSTATUS, 8'h00, 13'h0000);
    send(OP_RDSTATUS, 8'hFF, 13'h1FFF);
    send(OP_WRCTRL, 8'h00, 13'h0000);
    send(OP_WRMASK, 8'hFF, 13'h1FFF);
    send(OP_WROAMADDR, 8'hFF, 13'h0000);
    send(OP_WROAM, 8'hA5, 13'h1FFF);
    send(OP_WROAMADDR, 8'hFF, 13'h0000);
    send(OP_RDOAM, 8'h00, 13'h0000);
    send(OP_WRSCROLL, 8'h12, 13'h0000);
    send(OP_WRSCROLL, 8'h34, 13'h0000);
    send(OP_WRADDR, 8'hFF, 13'h0000);
    send(OP_WRADDR, 8'hFF, 13'h0000);
    send(OP_WRDATA, 8'h5A, 13'h0000);
    send(OP_WRADDR, 8'h20, 13'h0000);
    send(OP_WRADDR, 8'h00, 13'h0000);
    send(OP_WRDATA, 8'hC3, 13'h0000);
    send(OP_LOADCHR, 8'hFF, 13'h1FFF);
    send(OP_LOADCHR, 8'h00, 13'h0000);
    send(OP_UNUSED_LAST, 8'hFF, 13'h1FFF);
    send(OP_WRCTRL, 8'h04, 13'h0000);
    send(OP_WRADDR, 8'h20, 13'h0000);
    send(OP_WRADDR, 8'h00, 13'h0000);
    send(OP_RDDATA, 8'h00, 13'h0000);
    send(OP_RDDATA, 8'h00, 13'h0000);

    // Random phases with the cartridge attached and detached in turn.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      wait_for_results();
      write_cartridge(phase[0] == 1'b0);
      while (items_sent < ITEMS_PER_PHASE * (phase + 1)) random_sequence();
    end

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("ppu_register_port_tb: PASS");
    end else begin
      $display("ppu_register_port_tb: FAIL");
    end
    $finish;
  end

endmodule
